FILE: src/sawr_pkg.sv
// Shared types and constants for the stop-and-wait frame receiver.
// No dependencies; imported by every module of the block but the body store.
`default_nettype none
package sawr_pkg;

	localparam int MAX_BODY_BYTES_DEF = 16;

	localparam logic [7:0] FLAG_BYTE   = 8'h7E;
	localparam logic [7:0] LINK_ADDR_RST = 8'h03;

	// Control bytes that may appear in a received frame.
	localparam logic [7:0] CTL_I0  = 8'h00;
	localparam logic [7:0] CTL_I1  = 8'h40;
	localparam logic [7:0] CTL_UI  = 8'h03;
	localparam logic [7:0] CTL_X0B = 8'h0B;
	localparam logic [7:0] CTL_X07 = 8'h07;

	// Supervisory control bytes placed in replies.
	localparam logic [7:0] CTL_RR0  = 8'h05;
	localparam logic [7:0] CTL_RR1  = 8'h85;
	localparam logic [7:0] CTL_REJ0 = 8'h01;
	localparam logic [7:0] CTL_REJ1 = 8'h81;

	localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [1:0] VERDICT_BAD    = 2'd1;
	localparam logic [1:0] VERDICT_DUP    = 2'd2;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPLY   = 1'b1;

	localparam int REPLY_LEN = 5;
	localparam int RIDX_W    = $clog2(REPLY_LEN);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_FLAG,
		PH_ADDR,
		PH_CTRL,
		PH_BODY
	} rx_phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PAY_RD,
		BK_PAY_WR,
		BK_REPLY
	} back_state_t;

	// Outcome of one closed frame, handed from the front to the back.
	typedef struct packed {
		logic [1:0] verdict;
		logic [7:0] ctrl;
	} frame_cmd_t;

	function automatic logic control_allowed(input logic [7:0] c);
		return (c == CTL_I0) || (c == CTL_I1) || (c == CTL_UI) ||
			(c == CTL_X0B) || (c == CTL_X07);
	endfunction

endpackage
`default_nettype wire

FILE: src/sawr_ram.sv
// Body byte store: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module sawr_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/sawr_front.sv
// Receive side: flag hunt, header checks, body capture and frame verdict.
// Depends on sawr_pkg; writes the body store and posts one command per frame closed with a non-empty body.
`default_nettype none
module sawr_front
	import sawr_pkg::*;
#(
	parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF,
	parameter int AW             = $clog2(MAX_BODY_BYTES),
	parameter int CW             = $clog2(MAX_BODY_BYTES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [7:0]    link_address,
	input  wire logic          back_busy,
	input  wire logic          cmd_take,
	output logic               cmd_valid,
	output frame_cmd_t         cmd,
	output logic      [CW-1:0] cmd_plen,
	output logic               mem_we,
	output logic      [AW-1:0] mem_waddr,
	output logic      [7:0]    mem_wdata
);

	rx_phase_t  phase_q, phase_d;
	logic [7:0] control_seen_q;
	logic [CW-1:0] count_q;
	logic [7:0] xor_q;
	logic [7:0] last_q;
	logic       exp_seq_q;
	logic       cmd_valid_q;
	frame_cmd_t cmd_q;
	logic [CW-1:0] plen_q;

	logic       acc;
	logic       is_flag;
	logic       room;
	logic       close_frame;
	logic       good;
	logic       seq;
	frame_cmd_t cmd_new;
	logic [CW-1:0] plen_new;

	assign acc     = push && !full;
	assign is_flag = (rx_byte == FLAG_BYTE);
	assign room    = (count_q < CW'(MAX_BODY_BYTES));

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			case (phase_q)
				PH_FLAG: begin
					if (is_flag)                      phase_d = PH_FLAG;
					else if (rx_byte == link_address) phase_d = PH_ADDR;
					else                              phase_d = PH_HUNT;
				end
				PH_ADDR: begin
					if (is_flag)                       phase_d = PH_FLAG;
					else if (control_allowed(rx_byte)) phase_d = PH_CTRL;
					else                               phase_d = PH_HUNT;
				end
				PH_CTRL: begin
					// A byte equal to the header check wins even when it is the flag.
					if (rx_byte == (link_address ^ control_seen_q)) phase_d = PH_BODY;
					else if (is_flag)                               phase_d = PH_FLAG;
					else                                            phase_d = PH_HUNT;
				end
				PH_BODY: begin
					if (is_flag)   phase_d = PH_HUNT;
					else if (room) phase_d = PH_BODY;
					else           phase_d = PH_HUNT;
				end
				default: begin
					phase_d = is_flag ? PH_FLAG : PH_HUNT;
				end
			endcase
		end
	end

	// Outputs and frame verdict.
	always_comb begin
		// Body bytes and the closing flag wait until the back has finished with the store.
		full        = (phase_q == PH_BODY) && (back_busy || cmd_valid_q);
		mem_we      = acc && (phase_q == PH_BODY) && !is_flag && room;
		mem_waddr   = count_q[AW-1:0];
		mem_wdata   = rx_byte;
		close_frame = acc && (phase_q == PH_BODY) && is_flag && (count_q != '0);
		seq         = (control_seen_q == CTL_I1);
		// The running XOR covers the check byte too, so this is payload XOR against check.
		good        = ((xor_q ^ last_q) == last_q);
		plen_new    = '0;
		if (seq == exp_seq_q) begin
			if (good) begin
				cmd_new.verdict = VERDICT_ACCEPT;
				cmd_new.ctrl    = exp_seq_q ? CTL_RR0 : CTL_RR1;
				plen_new        = count_q - CW'(1);
			end else begin
				cmd_new.verdict = VERDICT_BAD;
				cmd_new.ctrl    = exp_seq_q ? CTL_REJ1 : CTL_REJ0;
			end
		end else begin
			cmd_new.verdict = VERDICT_DUP;
			cmd_new.ctrl    = exp_seq_q ? CTL_RR1 : CTL_RR0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			control_seen_q <= '0;
			count_q        <= '0;
			exp_seq_q      <= 1'b0;
			cmd_valid_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (cmd_take) begin
				cmd_valid_q <= 1'b0;
			end
			if (acc) begin
				case (phase_q)
					PH_ADDR: begin
						if (!is_flag && control_allowed(rx_byte)) begin
							control_seen_q <= rx_byte;
						end
					end
					PH_CTRL: begin
						if (phase_d == PH_BODY) begin
							count_q <= '0;
						end
					end
					PH_BODY: begin
						if (is_flag || !room) begin
							count_q <= '0;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (close_frame) begin
							cmd_valid_q <= 1'b1;
							if (seq == exp_seq_q && good) begin
								exp_seq_q <= !exp_seq_q;
							end
						end
					end
					PH_FLAG: begin
					end
					default: begin
						count_q <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (phase_q == PH_CTRL) && (phase_d == PH_BODY)) begin
			xor_q <= '0;
		end
		if (mem_we) begin
			xor_q  <= xor_q ^ rx_byte;
			last_q <= rx_byte;
		end
		if (close_frame) begin
			cmd_q  <= cmd_new;
			plen_q <= plen_new;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;
	assign cmd_plen  = plen_q;

endmodule
`default_nettype wire

FILE: src/sawr_back.sv
// Emit side: plays out any accepted payload bytes from the body store, then the reply frame.
// Depends on sawr_pkg; drives the read port of the store and the result register.
`default_nettype none
module sawr_back
	import sawr_pkg::*;
#(
	parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF,
	parameter int AW             = $clog2(MAX_BODY_BYTES),
	parameter int CW             = $clog2(MAX_BODY_BYTES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire frame_cmd_t    cmd,
	input  wire logic [CW-1:0] cmd_plen,
	output logic               cmd_take,
	output logic               busy,
	input  wire logic [7:0]    link_address,
	output logic               mem_re,
	output logic      [AW-1:0] mem_raddr,
	input  wire logic [7:0]    mem_rdata,
	output logic               empty,
	input  wire logic          pop,
	output logic               out_kind,
	output logic      [7:0]    out_byte,
	output logic      [1:0]    verdict,
	output logic               last
);

	back_state_t state_q, state_d;
	frame_cmd_t  cmd_q;
	logic [CW-1:0] plen_q;
	logic [AW-1:0] idx_q;
	logic [RIDX_W-1:0] ridx_q;

	logic       out_valid_q;
	logic       out_kind_q;
	logic [7:0] out_byte_q;
	logic [1:0] verdict_q;
	logic       last_q;

	logic       slot_free;
	logic       load;
	logic       pay_done;
	logic       reply_done;
	logic [7:0] reply_byte;

	assign slot_free  = !out_valid_q || pop;
	assign pay_done   = ((CW'(idx_q) + CW'(1)) == plen_q);
	assign reply_done = (ridx_q == RIDX_W'(REPLY_LEN - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd_plen != '0) ? BK_PAY_RD : BK_REPLY;
				end
			end
			BK_PAY_RD: begin
				state_d = BK_PAY_WR;
			end
			BK_PAY_WR: begin
				if (slot_free) begin
					state_d = pay_done ? BK_REPLY : BK_PAY_RD;
				end
			end
			BK_REPLY: begin
				if (slot_free && reply_done) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_take  = (state_q == BK_IDLE) && cmd_valid;
		busy      = (state_q != BK_IDLE);
		mem_re    = (state_q == BK_PAY_RD);
		mem_raddr = idx_q;
		load      = slot_free && ((state_q == BK_PAY_WR) || (state_q == BK_REPLY));
		case (ridx_q)
			RIDX_W'(1): reply_byte = link_address;
			RIDX_W'(2): reply_byte = cmd_q.ctrl;
			RIDX_W'(3): reply_byte = link_address ^ cmd_q.ctrl;
			default:    reply_byte = FLAG_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q  <= cmd;
			plen_q <= cmd_plen;
			idx_q  <= '0;
			ridx_q <= '0;
		end
		if (load) begin
			verdict_q <= cmd_q.verdict;
			if (state_q == BK_PAY_WR) begin
				out_kind_q <= KIND_PAYLOAD;
				out_byte_q <= mem_rdata;
				last_q     <= 1'b0;
				idx_q      <= idx_q + AW'(1);
			end else begin
				out_kind_q <= KIND_REPLY;
				out_byte_q <= reply_byte;
				last_q     <= reply_done;
				ridx_q     <= ridx_q + RIDX_W'(1);
			end
		end
	end

	assign empty    = !out_valid_q;
	assign out_kind = out_kind_q;
	assign out_byte = out_byte_q;
	assign verdict  = verdict_q;
	assign last     = last_q;

endmodule
`default_nettype wire

FILE: src/stop_and_wait_frame_receiver_core.sv
// Stop-and-wait frame receiver. A received byte is taken when push is high and full is low; body bytes
// and the closing flag wait while the previous frame's run is still being read out.
// At a closing flag the command is registered, the back takes it, reads the store for a run with
// payload and loads the result register (a reply only skips the read); payload bytes follow
// with one store read each, the 5 reply bytes one per cycle, all paced by pop.
// Reset clears the receive phase, sequence bit and result valid flag; the store is not cleared.
`default_nettype none
module stop_and_wait_frame_receiver_core
	import sawr_pkg::*;
#(
	parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	output logic            empty,
	input  wire logic       pop,
	output logic            out_kind,
	output logic      [7:0] out_byte,
	output logic      [1:0] verdict,
	output logic            last
);

	localparam int AW = $clog2(MAX_BODY_BYTES);
	localparam int CW = $clog2(MAX_BODY_BYTES + 1);

	logic [7:0]    link_address_q;
	logic          cmd_valid;
	logic          cmd_take;
	frame_cmd_t    cmd;
	logic [CW-1:0] cmd_plen;
	logic          back_busy;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_address_q <= LINK_ADDR_RST;
		end else if (cfg_we) begin
			link_address_q <= cfg_wdata;
		end
	end

	sawr_front #(
		.MAX_BODY_BYTES(MAX_BODY_BYTES),
		.AW(AW),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.link_address(link_address_q),
		.back_busy(back_busy),
		.cmd_take(cmd_take),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_plen(cmd_plen),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

	sawr_ram #(
		.DEPTH(MAX_BODY_BYTES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en(mem_re),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	sawr_back #(
		.MAX_BODY_BYTES(MAX_BODY_BYTES),
		.AW(AW),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_plen(cmd_plen),
		.cmd_take(cmd_take),
		.busy(back_busy),
		.link_address(link_address_q),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.empty(empty),
		.pop(pop),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.verdict(verdict),
		.last(last)
	);

endmodule
`default_nettype wire

FILE: test/stop_and_wait_frame_receiver_core_tb.sv
// Self-checking testbench for the stop-and-wait frame receiver core.
// Drives a directed table then random frames under several link addresses, checking
// every output item against a behavioural predictor. Depends on sawr_pkg and the core.
`timescale 1ns / 1ps
module stop_and_wait_frame_receiver_core_tb
	import sawr_pkg::*;
;

	localparam int MAX_BODY    = MAX_BODY_BYTES_DEF;
	localparam int SETTLE      = 10;
	localparam int DRAIN_LIMIT = 5000;
	localparam int NUM_ROWS    = 30;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [1:0] vd;
		logic       last;
	} out_item_t;

	// Expectation typed into a directed row; none marks a row that must give nothing.
	typedef struct packed {
		logic       typed;
		logic       none;
		logic [1:0] vd;
		logic [7:0] ctl;
	} hint_t;

	typedef struct packed {
		logic [7:0] b;
		hint_t      h;
	} row_t;

	localparam hint_t NO_HINT   = '0;
	localparam hint_t HINT_NONE = '{typed: 1'b1, none: 1'b1, vd: VERDICT_ACCEPT, ctl: 8'h00};
	localparam hint_t HINT_RR1  = '{typed: 1'b1, none: 1'b0, vd: VERDICT_ACCEPT, ctl: CTL_RR1};
	localparam hint_t HINT_REJ0 = '{typed: 1'b1, none: 1'b0, vd: VERDICT_BAD, ctl: CTL_REJ0};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	hint_t      hint = '0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       pop = 1'b0;
	wire        full;
	wire        empty;
	wire        out_kind;
	wire  [7:0] out_byte;
	wire  [1:0] verdict;
	wire        last;

	// Receiver state as the predictor sees it.
	rx_phase_t  frm_phase = PH_HUNT;
	logic [7:0] frm_ctl = 8'h00;
	int         frm_count = 0;
	logic [7:0] frm_store [MAX_BODY];
	logic       frm_seq = 1'b0;
	logic [7:0] link_reg = LINK_ADDR_RST;

	out_item_t  run_q[$];
	out_item_t  pending_out[$];
	row_t       directed_rows [NUM_ROWS];
	int         errors = 0;
	int         items_sent = 0;
	bit         calm = 1'b0;

	stop_and_wait_frame_receiver_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.rx_byte  (rx_byte),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.empty    (empty),
		.pop      (pop),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.verdict  (verdict),
		.last     (last)
	);

	always #1 clk = ~clk;

	task automatic emit_reply(input logic [7:0] ctl, input logic [1:0] vd);
		run_q.push_back('{KIND_REPLY, FLAG_BYTE, vd, 1'b0});
		run_q.push_back('{KIND_REPLY, link_reg, vd, 1'b0});
		run_q.push_back('{KIND_REPLY, ctl, vd, 1'b0});
		run_q.push_back('{KIND_REPLY, link_reg ^ ctl, vd, 1'b0});
		run_q.push_back('{KIND_REPLY, FLAG_BYTE, vd, 1'b1});
	endtask

	task automatic close_frame();
		int         n;
		logic [7:0] calc;
		logic       seq;
		n = frm_count;
		calc = 8'h00;
		frm_phase = PH_HUNT;
		frm_count = 0;
		if (n >= 1) begin
			for (int j = 0; j < n - 1; j++)
				calc ^= frm_store[j];
			seq = (frm_ctl == CTL_I1);
			if (seq != frm_seq) begin
				emit_reply(frm_seq ? CTL_RR1 : CTL_RR0, VERDICT_DUP);
			end else if (calc == frm_store[n - 1]) begin
				for (int j = 0; j < n - 1; j++)
					run_q.push_back('{KIND_PAYLOAD, frm_store[j], VERDICT_ACCEPT, 1'b0});
				frm_seq = ~frm_seq;
				emit_reply(frm_seq ? CTL_RR1 : CTL_RR0, VERDICT_ACCEPT);
			end else begin
				emit_reply(frm_seq ? CTL_REJ1 : CTL_REJ0, VERDICT_BAD);
			end
		end
	endtask

	// Advances the predicted receiver by one byte, leaving any output items in run_q.
	task automatic receive_byte(input logic [7:0] b);
		run_q.delete();
		case (frm_phase)
			PH_FLAG: begin
				if (b == FLAG_BYTE)
					frm_phase = PH_FLAG;
				else if (b == link_reg)
					frm_phase = PH_ADDR;
				else
					frm_phase = PH_HUNT;
			end
			PH_ADDR: begin
				if (b == FLAG_BYTE) begin
					frm_phase = PH_FLAG;
				end else if (b == CTL_I0 || b == CTL_I1 || b == CTL_UI ||
						b == CTL_X0B || b == CTL_X07) begin
					frm_ctl = b;
					frm_phase = PH_CTRL;
				end else begin
					frm_phase = PH_HUNT;
				end
			end
			PH_CTRL: begin
				// The header check wins over the flag when the two are equal.
				if (b == (link_reg ^ frm_ctl)) begin
					frm_count = 0;
					frm_phase = PH_BODY;
				end else if (b == FLAG_BYTE) begin
					frm_phase = PH_FLAG;
				end else begin
					frm_phase = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (b == FLAG_BYTE) begin
					close_frame();
				end else if (frm_count < MAX_BODY) begin
					frm_store[frm_count] = b;
					frm_count++;
				end else begin
					frm_count = 0;
					frm_phase = PH_HUNT;
				end
			end
			default: begin
				frm_count = 0;
				frm_phase = (b == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
			end
		endcase
	endtask

	task automatic check_output();
		out_item_t want;
		if (pending_out.size() == 0) begin
			$display("%0t: unexpected output kind=%0d byte=%02h verdict=%0d last=%0d",
				$time, out_kind, out_byte, verdict, last);
			errors++;
		end else begin
			want = pending_out.pop_front();
			if ({out_kind, out_byte, verdict, last} !== want) begin
				$display("%0t: mismatch expected kind=%0d byte=%02h verdict=%0d last=%0d",
					$time, want.kind, want.data, want.vd, want.last);
				$display("%0t:          actual   kind=%0d byte=%02h verdict=%0d last=%0d",
					$time, out_kind, out_byte, verdict, last);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_output();
			if (push && !full) begin
				receive_byte(rx_byte);
				if (hint.typed) begin
					run_q.delete();
					if (!hint.none)
						emit_reply(hint.ctl, hint.vd);
				end
				pending_out = {pending_out, run_q};
			end
			if (cfg_we)
				link_reg = cfg_wdata;
		end
	end

	always @(posedge clk)
		pop <= calm || ($urandom_range(0, 99) >= 17);

	// Called just after a rising edge; returns at the edge where the item was taken.
	task automatic send_byte(input logic [7:0] b, input hint_t h);
		if (!calm && $urandom_range(0, 99) < 17) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		hint <= h;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		push <= 1'b0;
		// Wait so that the predictor has taken the last item sent.
		@(posedge clk);
		while (pending_out.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_link(input logic [7:0] a);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_ctl();
		case ($urandom_range(0, 5))
			0: return CTL_I0;
			1, 2: return CTL_I1;
			3: return CTL_UI;
			4: return CTL_X0B;
			default: return CTL_X07;
		endcase
	endfunction

	function automatic logic [7:0] non_flag();
		logic [7:0] b;
		do b = 8'($urandom); while (b == FLAG_BYTE);
		return b;
	endfunction

	task automatic send_header(input logic [7:0] ctl);
		send_byte(FLAG_BYTE, NO_HINT);
		send_byte(link_reg, NO_HINT);
		send_byte(ctl, NO_HINT);
		send_byte(link_reg ^ ctl, NO_HINT);
	endtask

	task automatic send_frame(input bit bad_check);
		logic [7:0] ctl;
		logic [7:0] chk;
		logic [7:0] b;
		logic [7:0] body[$];
		int         plen;
		case ($urandom_range(0, 7))
			0: plen = MAX_BODY - 1;
			1: plen = $urandom_range(5, MAX_BODY - 2);
			default: plen = $urandom_range(0, 4);
		endcase
		ctl = pick_ctl();
		// A payload check equal to the flag would close the frame early.
		do begin
			body.delete();
			chk = 8'h00;
			for (int i = 0; i < plen; i++) begin
				b = non_flag();
				body.push_back(b);
				chk ^= b;
			end
			if (bad_check)
				chk ^= 8'($urandom_range(1, 255));
		end while (chk == FLAG_BYTE);
		send_header(ctl);
		foreach (body[i])
			send_byte(body[i], NO_HINT);
		send_byte(chk, NO_HINT);
		send_byte(FLAG_BYTE, NO_HINT);
	endtask

	task automatic random_phase(input int n);
		int stop_at;
		int r;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_frame(1'b0);
			end else if (r < 75) begin
				send_frame(1'b1);
			end else if (r < 83) begin
				send_header(pick_ctl());
				repeat ($urandom_range(MAX_BODY + 1, MAX_BODY + 3))
					send_byte(non_flag(), NO_HINT);
			end else if (r < 92) begin
				send_byte(FLAG_BYTE, NO_HINT);
				send_byte($urandom_range(0, 1) ? link_reg : 8'($urandom), NO_HINT);
				send_byte($urandom_range(0, 1) ? pick_ctl() : 8'($urandom), NO_HINT);
				send_byte(8'($urandom), NO_HINT);
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte($urandom_range(0, 3) == 0 ? FLAG_BYTE : 8'($urandom), NO_HINT);
			end
		end
	endtask

	initial begin
		directed_rows = '{
			'{8'h7E, NO_HINT}, '{8'h03, NO_HINT},
			'{8'h7E, NO_HINT},                     // flag in the address phase
			'{8'h03, NO_HINT}, '{8'h00, NO_HINT},
			'{8'h7E, NO_HINT},                     // flag in the check phase
			'{8'h03, NO_HINT}, '{8'h00, NO_HINT}, '{8'h03, NO_HINT},
			'{8'h7E, HINT_NONE},                   // closing flag with an empty body
			'{8'h7E, NO_HINT}, '{8'h03, NO_HINT}, '{8'h00, NO_HINT}, '{8'h03, NO_HINT},
			'{8'h00, NO_HINT},
			'{8'h7E, HINT_RR1},                    // empty payload, new and good
			'{8'h7E, NO_HINT}, '{8'h03, NO_HINT}, '{8'h40, NO_HINT}, '{8'h43, NO_HINT},
			'{8'hFF, NO_HINT}, '{8'h00, NO_HINT}, '{8'hFF, NO_HINT}, '{8'h7E, NO_HINT},
			'{8'h7E, NO_HINT}, '{8'h03, NO_HINT}, '{8'h00, NO_HINT}, '{8'h03, NO_HINT},
			'{8'hAA, NO_HINT},
			'{8'h7E, HINT_REJ0}                    // new frame with a bad payload check
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].h);

		set_link(8'hFF);
		random_phase(20);
		set_link(8'h00);
		calm = 1'b1;
		random_phase(20);
		calm = 1'b0;
		// With this address a control of 0x03 makes the header check equal the flag.
		set_link(8'h7D);
		random_phase(20);
		set_link(8'($urandom));
		random_phase(20);
		drain();

		if (pending_out.size() != 0) begin
			$display("%0t: %0d expected output items never arrived", $time, pending_out.size());
			errors++;
		end
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#500000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
src/sawr_pkg.sv
src/sawr_ram.sv
src/sawr_front.sv
src/sawr_back.sv
src/stop_and_wait_frame_receiver_core.sv
test/stop_and_wait_frame_receiver_core_tb.sv
